[sv/tti_pkg.sv]
`timescale 1ns / 1ps

package tti_pkg;

  localparam int TableDepthDefault = 64;

  localparam int OpW      = 1;
  localparam int IndexW   = 6;
  localparam int SampleW  = 16;
  localparam int TempW    = 20;
  localparam int KindW    = 2;
  localparam int TempRegW = 8;
  localparam int StepW    = 8;
  localparam int LenRegW  = 7;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;

  // quotient of 16*step*a/b stays below 16*256 since a < b
  localparam int QuotW    = 12;
  localparam int DivCntW  = $clog2(QuotW);

  localparam logic [TempRegW-1:0] TempMinReset  = 8'hE7;  // -25
  localparam logic [TempRegW-1:0] TempMaxReset  = 8'd105;
  localparam logic [StepW-1:0]    TempStepReset = 8'd5;
  localparam logic [LenRegW-1:0]  LengthReset   = 7'd1;
  localparam logic                FallingReset  = 1'b0;

  localparam logic [OpW-1:0] OpWrite   = 1'b0;
  localparam logic [OpW-1:0] OpConvert = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_MIN  = 3'd0,
    CFG_TEMP_MAX  = 3'd1,
    CFG_TEMP_STEP = 3'd2,
    CFG_LENGTH    = 3'd3,
    CFG_FALLING   = 3'd4
  } cfg_idx_e;

  typedef enum logic [KindW-1:0] {
    KIND_BELOW  = 2'd0,
    KIND_INTERP = 2'd1,
    KIND_BEYOND = 2'd2,
    KIND_ACK    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    RES_ACK,
    RES_MIN,
    RES_MAX,
    RES_INTERP
  } res_sel_e;

  typedef struct packed {
    logic     mem_we;
    logic     scan_init;
    logic     rd_inc;
    logic     scan_next;
    logic     capture;
    logic     mult;
    logic     div_load;
    logic     div_step;
    logic     res_load;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic hit;
    logic first;
    logic last;
    logic div_done;
  } sts_t;

endpackage

[sv/tti_ctrl.sv]
`timescale 1ns / 1ps

module tti_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tti_pkg::OpW-1:0]       op_i,
  output logic                          busy_o,
  output tti_pkg::cmd_t                 cmd_o,
  input  tti_pkg::sts_t                 sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_MULT,
    ST_LOAD,
    ST_DIV,
    ST_FIX
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (op_i == tti_pkg::OpWrite) begin
            cmd_o.mem_we   = 1'b1;
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = tti_pkg::RES_ACK;
          end else begin
            cmd_o.scan_init = 1'b1;
            if (sts_i.len_zero) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = tti_pkg::RES_MAX;
            end else begin
              state_d = ST_PRIME;
            end
          end
        end
      end
      ST_PRIME: begin
        cmd_o.rd_inc = 1'b1;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.hit) begin
          if (sts_i.first) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = tti_pkg::RES_MIN;
            state_d        = ST_IDLE;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = ST_MULT;
          end
        end else if (sts_i.last) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = tti_pkg::RES_MAX;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = tti_pkg::RES_INTERP;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

[sv/tti_datapath.sv]
`timescale 1ns / 1ps

module tti_datapath #(
  parameter int TABLE_DEPTH = tti_pkg::TableDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tti_pkg::cmd_t                     cmd_i,
  output tti_pkg::sts_t                     sts_o,
  input  logic [tti_pkg::IndexW-1:0]        entry_index_i,
  input  logic [tti_pkg::SampleW-1:0]       entry_value_i,
  input  logic [tti_pkg::SampleW-1:0]       sample_i,
  input  logic                              cfg_we_i,
  input  logic [tti_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [tti_pkg::CfgDataW-1:0]      cfg_wdata_i,
  output logic signed [tti_pkg::TempW-1:0]  temperature_o,
  output logic [tti_pkg::KindW-1:0]         kind_o,
  output logic                              done_o
);

  localparam int IdxW  = $clog2(TABLE_DEPTH);
  localparam int LenW  = $clog2(TABLE_DEPTH + 1);
  localparam int CmpW  = (LenW > tti_pkg::LenRegW) ? LenW : tti_pkg::LenRegW;
  localparam int WideW = (IdxW > tti_pkg::IndexW) ? IdxW : tti_pkg::IndexW;
  localparam int ProdW = tti_pkg::StepW + IdxW;
  localparam int SumW  = ProdW + 2;
  localparam int BaseW = SumW + 4;
  localparam int ResW  = (BaseW + 1 > tti_pkg::TempW) ? BaseW + 1 : tti_pkg::TempW;
  localparam int SaW   = tti_pkg::StepW + tti_pkg::SampleW;
  localparam int DivW  = SaW + 4;
  localparam int SW    = tti_pkg::SampleW;
  localparam int QW    = tti_pkg::QuotW;
  localparam int ExtW  = tti_pkg::TempW - tti_pkg::TempRegW - 4;

  // configuration
  logic signed [tti_pkg::TempRegW-1:0] tmin_q, tmax_q;
  logic [tti_pkg::StepW-1:0]           step_q;
  logic [tti_pkg::LenRegW-1:0]         length_q;
  logic                                falling_q;

  // scan
  logic [SW-1:0]   cal_mem_q [TABLE_DEPTH];
  logic [SW-1:0]   rdata_q;
  logic [IdxW-1:0] rd_idx_q, cmp_idx_q;
  logic [SW-1:0]   sample_q, prev_q;
  logic [SW-1:0]   a_q, b_q;
  logic [IdxW-1:0] i_q;

  // arithmetic
  logic [SaW-1:0]           sa_q;
  logic signed [BaseW-1:0]  base_q;
  logic [SW-1:0]            rem_q;
  logic [QW-1:0]            quo_q;
  logic [tti_pkg::DivCntW-1:0] div_cnt_q;

  // result
  logic                             done_q;
  logic signed [tti_pkg::TempW-1:0] temp_q, temp_d;
  logic [tti_pkg::KindW-1:0]        kind_q, kind_d;

  logic [WideW-1:0] wr_wide;
  logic [IdxW-1:0]  wr_addr;
  logic             wr_ok;
  logic [CmpW-1:0]  len_ext, len_eff;
  logic             hit;
  logic [SW-1:0]    a_c, b_c;
  logic [ProdW-1:0] prod_si;
  logic signed [SumW-1:0] sum_c;
  logic [DivW-1:0]  dividend;
  logic [SW:0]      rem_sh;
  logic             q_bit;
  logic [SW-1:0]    rem_nx;
  logic signed [ResW-1:0] t_c, t_fix;

  assign wr_wide = WideW'(entry_index_i);
  assign wr_addr = wr_wide[IdxW-1:0];
  assign wr_ok   = CmpW'(entry_index_i) < CmpW'(TABLE_DEPTH);

  assign len_ext = CmpW'(length_q);
  assign len_eff = (len_ext > CmpW'(TABLE_DEPTH)) ? CmpW'(TABLE_DEPTH) : len_ext;

  assign hit = falling_q ? (rdata_q <= sample_q) : (rdata_q >= sample_q);
  assign a_c = falling_q ? (sample_q - rdata_q) : (rdata_q - sample_q);
  assign b_c = falling_q ? (prev_q - rdata_q) : (rdata_q - prev_q);

  assign sts_o.len_zero = (len_eff == '0);
  assign sts_o.hit      = hit;
  assign sts_o.first    = (cmp_idx_q == '0);
  assign sts_o.last     = (CmpW'(cmp_idx_q) + CmpW'(1)) == len_eff;
  assign sts_o.div_done = (div_cnt_q == tti_pkg::DivCntW'(QW - 1));

  assign prod_si  = ProdW'(step_q) * ProdW'(i_q);
  assign sum_c    = SumW'(tmin_q) + $signed({2'b00, prod_si});
  assign dividend = {sa_q, 4'b0000};

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_q, quo_q[QW-1]};
  assign q_bit  = (rem_sh >= {1'b0, b_q});
  always_comb begin
    rem_nx = rem_sh[SW-1:0];
    if (q_bit) begin
      rem_nx = SW'(rem_sh - {1'b0, b_q});
    end
  end

  // trunc toward zero of base - q/b
  assign t_c   = ResW'(base_q) - ResW'($signed({1'b0, quo_q}));
  assign t_fix = ((rem_q != '0) && (t_c > 0)) ? (t_c - ResW'(1)) : t_c;

  always_comb begin
    temp_d = '0;
    kind_d = tti_pkg::KIND_ACK;
    case (cmd_i.res_sel)
      tti_pkg::RES_ACK: begin
        temp_d = '0;
        kind_d = tti_pkg::KIND_ACK;
      end
      tti_pkg::RES_MIN: begin
        temp_d = {{ExtW{tmin_q[tti_pkg::TempRegW-1]}}, tmin_q, 4'b0000};
        kind_d = tti_pkg::KIND_BELOW;
      end
      tti_pkg::RES_MAX: begin
        temp_d = {{ExtW{tmax_q[tti_pkg::TempRegW-1]}}, tmax_q, 4'b0000};
        kind_d = tti_pkg::KIND_BEYOND;
      end
      tti_pkg::RES_INTERP: begin
        temp_d = t_fix[tti_pkg::TempW-1:0];
        kind_d = tti_pkg::KIND_INTERP;
      end
      default: begin
        temp_d = '0;
        kind_d = tti_pkg::KIND_ACK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmin_q    <= tti_pkg::TempMinReset;
      tmax_q    <= tti_pkg::TempMaxReset;
      step_q    <= tti_pkg::TempStepReset;
      length_q  <= tti_pkg::LengthReset;
      falling_q <= tti_pkg::FallingReset;
      rd_idx_q  <= '0;
      cmp_idx_q <= '0;
      div_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tti_pkg::CFG_TEMP_MIN:  tmin_q    <= cfg_wdata_i;
          tti_pkg::CFG_TEMP_MAX:  tmax_q    <= cfg_wdata_i;
          tti_pkg::CFG_TEMP_STEP: step_q    <= cfg_wdata_i;
          tti_pkg::CFG_LENGTH:    length_q  <= cfg_wdata_i[tti_pkg::LenRegW-1:0];
          tti_pkg::CFG_FALLING:   falling_q <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
      if (cmd_i.scan_init) begin
        rd_idx_q  <= '0;
        cmp_idx_q <= '0;
      end else if (cmd_i.rd_inc) begin
        rd_idx_q <= rd_idx_q + IdxW'(1);
      end else if (cmd_i.scan_next) begin
        rd_idx_q  <= rd_idx_q + IdxW'(1);
        cmp_idx_q <= cmp_idx_q + IdxW'(1);
      end
      if (cmd_i.div_load) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + tti_pkg::DivCntW'(1);
      end
      done_q <= cmd_i.res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we && wr_ok) begin
      cal_mem_q[wr_addr] <= entry_value_i;
    end
    rdata_q <= cal_mem_q[rd_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      sample_q <= sample_i;
    end
    if (cmd_i.scan_next) begin
      prev_q <= rdata_q;
    end
    if (cmd_i.capture) begin
      a_q <= a_c;
      b_q <= b_c;
      i_q <= cmp_idx_q;
    end
    if (cmd_i.mult) begin
      sa_q   <= SaW'(step_q) * SaW'(a_q);
      base_q <= {sum_c, 4'b0000};
    end
    if (cmd_i.div_load) begin
      rem_q <= SW'(dividend[DivW-1:QW]);
      quo_q <= dividend[QW-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_nx;
      quo_q <= {quo_q[QW-2:0], q_bit};
    end
    if (cmd_i.res_load) begin
      temp_q <= temp_d;
      kind_q <= kind_d;
    end
  end

  assign temperature_o = temp_q;
  assign kind_o        = kind_q;
  assign done_o        = done_q;

endmodule

[sv/thermistor_table_interpolator.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// command   in         start_i, busy_o          op_i, entry_index_i, entry_value_i, sample_i
// result    out        done_o (one-cycle word)  temperature_o, kind_o
// config    in         cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// A word is taken when start_i is high and busy_o low. A table write returns its
// acknowledge in the next cycle and leaves busy_o low. A convert does one memory
// read per cycle for the scan; when it interpolates, the scan is followed by a
// multiply and a restoring divider. Reset is asynchronous, active low; table
// contents are kept only by writes. The receiver cannot stall: done_o is high
// for one cycle.

module thermistor_table_interpolator #(
  parameter int TABLE_DEPTH = tti_pkg::TableDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [tti_pkg::OpW-1:0]           op_i,
  input  logic [tti_pkg::IndexW-1:0]        entry_index_i,
  input  logic [tti_pkg::SampleW-1:0]       entry_value_i,
  input  logic [tti_pkg::SampleW-1:0]       sample_i,
  output logic                              done_o,
  output logic signed [tti_pkg::TempW-1:0]  temperature_o,
  output logic [tti_pkg::KindW-1:0]         kind_o,
  input  logic                              cfg_we_i,
  input  logic [tti_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [tti_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  tti_pkg::cmd_t cmd;
  tti_pkg::sts_t sts;

  tti_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  tti_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .sample_i      (sample_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .temperature_o (temperature_o),
    .kind_o        (kind_o),
    .done_o        (done_o)
  );

endmodule
